@@ sv/ilf_pkg.sv @@
package ilf_pkg;

	localparam int SW = 16;
	localparam int MULW = SW + 1;
	localparam int RMSW = 16;
	localparam int TRIALW = 16;
	localparam int IDXW = 10;
	localparam int SCW = 11;
	localparam int GAINW = 15;
	localparam int DGAINW = 16;
	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FORGET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PROP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX    = 3'd6;

	typedef enum logic [1:0] {
		FN_READ   = 2'd0,
		FN_RECORD = 2'd1,
		FN_END    = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef struct packed {
		func_t                func;
		logic [IDXW-1:0]      sample_index;
		logic signed [SW-1:0] error_value;
	} in_t;

	typedef struct packed {
		logic signed [SW-1:0] drive_value;
		logic [RMSW-1:0]      rms_error;
		logic [TRIALW-1:0]    trial_number;
	} out_t;

endpackage

@@ sv/ilf_mul.sv @@
module ilf_mul (
	input  logic                                 clk,
	input  logic signed [ilf_pkg::MULW-1:0]      a,
	input  logic signed [ilf_pkg::MULW-1:0]      b,
	output logic signed [2*ilf_pkg::MULW-1:0]    p
);
	import ilf_pkg::*;

	logic signed [2*MULW-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

@@ sv/ilf_root.sv @@
module ilf_root #(
	parameter int SUMW = 2 * ilf_pkg::SW + 11,
	parameter int CW = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [SUMW-1:0]            sum,
	input  logic [CW-1:0]              count,
	output logic                       done,
	output logic [ilf_pkg::RMSW-1:0]   root
);
	import ilf_pkg::*;

	localparam int XW = 2 * SW;
	localparam int NW = $clog2(SUMW + 1);

	typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT} rstate_t;

	rstate_t         state_q;
	logic [NW-1:0]   cnt_q;
	logic [SUMW-1:0] dq_q;
	logic [CW-1:0]   rem_q;
	logic [XW-1:0]   x_q;
	logic [XW-1:0]   res_q;
	logic [XW-1:0]   bit_q;
	logic            done_q;
	logic [RMSW-1:0] root_q;

	logic [CW:0]     trial;
	logic            ge;
	logic [CW:0]     diff;
	logic [XW-1:0]   t;
	logic            sq_ge;
	logic [XW-1:0]   res_n;

	always_comb begin
		trial = {rem_q, dq_q[SUMW-1]};
		ge = trial >= {1'b0, count};
		diff = trial - {1'b0, count};
		t = res_q + bit_q;
		sq_ge = x_q >= t;
		res_n = sq_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				R_IDLE: begin
					if (start) begin
						dq_q <= sum;
						rem_q <= '0;
						cnt_q <= '0;
						state_q <= R_DIV;
					end
				end
				R_DIV: begin
					rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
					dq_q <= {dq_q[SUMW-2:0], ge};
					cnt_q <= cnt_q + NW'(1);
					if (cnt_q == NW'(SUMW - 1)) begin
						x_q <= {dq_q[XW-2:0], ge};
						res_q <= '0;
						bit_q <= XW'(1) << (XW - 2);
						cnt_q <= '0;
						state_q <= R_SQRT;
					end
				end
				R_SQRT: begin
					if (sq_ge) begin
						x_q <= x_q - t;
					end
					res_q <= res_n;
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q + NW'(1);
					if (cnt_q == NW'(SW - 1)) begin
						root_q <= res_n[RMSW-1:0];
						done_q <= 1'b1;
						state_q <= R_IDLE;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ sv/iterative_learning_feedforward_core.sv @@
// Iterative learning feedforward table. Commands are taken when start is high and busy is
// low; each command gives exactly one result, shown on result for a single cycle with done
// high, and the receiver cannot stall it. A read or a record holds busy high through its
// response state, and the result follows in the cycle after. An end of trial walks the N
// used entries through one shared 17 by 17 multiplier, then runs a bit-serial divider and a
// 16-step square root for the RMS error while the error entries beyond N are zeroed, one a
// cycle; the longer of the two sets the tail. After reset the block sweeps both tables to
// zero, with busy high, before it takes its first command; configuration writes are taken
// at any time.
module iterative_learning_feedforward_core #(
	parameter int MAX_SAMPLES = ilf_pkg::MAX_SAMPLES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  ilf_pkg::in_t                      cmd,
	output logic                              done,
	output ilf_pkg::out_t                     result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ilf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ilf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ilf_pkg::*;

	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int SUMW = 2 * SW + CW;
	localparam int ACCW = 2 * MULW + 8;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RESP, S_U_RD, S_U_SQ, S_U_FU, S_U_PE, S_U_DR, S_U_AD, S_U_WR, S_SWEEP
	} state_t;

	// configuration
	logic                     mode_q;
	logic [SCW-1:0]           scount_q;
	logic [GAINW-1:0]         fgain_q;
	logic [GAINW-1:0]         pgain_q;
	logic signed [DGAINW-1:0] dgain_q;
	logic signed [SW-1:0]     dmin_q;
	logic signed [SW-1:0]     dmax_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			scount_q <= SCW'(1024);
			fgain_q <= GAINW'(16384);
			pgain_q <= '0;
			dgain_q <= '0;
			dmin_q <= {1'b1, {(SW-1){1'b0}}};
			dmax_q <= {1'b0, {(SW-1){1'b1}}};
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:   mode_q <= cfg_data[0];
				REG_COUNT:  scount_q <= cfg_data[SCW-1:0];
				REG_FORGET: fgain_q <= cfg_data[GAINW-1:0];
				REG_PROP:   pgain_q <= cfg_data[GAINW-1:0];
				REG_DERIV:  dgain_q <= $signed(cfg_data[DGAINW-1:0]);
				REG_MIN:    dmin_q <= $signed(cfg_data[SW-1:0]);
				REG_MAX:    dmax_q <= $signed(cfg_data[SW-1:0]);
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	state_t                   state_q;
	logic                     init_q;
	logic [CW-1:0]            k_q;
	func_t                    op_q;
	logic                     inr_q;
	logic [SUMW-1:0]          sum_q;
	logic signed [ACCW-1:0]   acc_q;
	logic signed [SW-1:0]     prev_q;
	logic signed [SW-1:0]     prior_q;
	logic [TRIALW-1:0]        trial_q;
	logic [RMSW-1:0]          rms_q;
	logic                     rdone_q;
	logic                     rstart_q;
	logic                     done_q;
	out_t                     result_q;

	logic signed [SW-1:0]     du_q;
	logic signed [SW-1:0]     de_q;
	logic signed [SW-1:0]     drive_mem [MAX_SAMPLES];
	logic signed [SW-1:0]     err_mem [MAX_SAMPLES];

	logic [CW-1:0]            n_used;
	logic                     in_range;
	logic                     accept;
	logic                     k_end;
	logic [AW-1:0]            rd_addr;
	logic                     dw_en;
	logic [AW-1:0]            dw_addr;
	logic signed [SW-1:0]     dw_data;
	logic                     ew_en;
	logic [AW-1:0]            ew_addr;
	logic signed [SW-1:0]     ew_data;
	logic signed [MULW-1:0]   mul_a;
	logic signed [MULW-1:0]   mul_b;
	logic signed [2*MULW-1:0] prod;
	logic signed [MULW-1:0]   e_ext;
	logic signed [MULW-1:0]   diff;
	logic signed [ACCW-1:0]   rnd;
	logic signed [ACCW-1:0]   sat_hi;
	logic signed [ACCW-1:0]   sat;
	logic                     rt_done;
	logic [RMSW-1:0]          rt_root;

	always_comb begin
		if (scount_q == '0) begin
			n_used = CW'(1);
		end else if (32'(scount_q) > 32'(MAX_SAMPLES)) begin
			n_used = CW'(MAX_SAMPLES);
		end else begin
			n_used = CW'(scount_q);
		end
		in_range = 32'(cmd.sample_index) < 32'(n_used);
		accept = start && (state_q == S_IDLE);
		k_end = k_q == CW'(MAX_SAMPLES);
		rd_addr = (state_q == S_IDLE) ? AW'(cmd.sample_index) : k_q[AW-1:0];

		e_ext = MULW'(de_q);
		diff = e_ext - MULW'(prev_q);
		mul_a = e_ext;
		mul_b = e_ext;
		case (state_q)
			S_U_FU: begin
				mul_a = $signed({{(MULW-GAINW){1'b0}}, fgain_q});
				mul_b = MULW'(du_q);
			end
			S_U_PE: begin
				mul_a = $signed({{(MULW-GAINW){1'b0}}, pgain_q});
				mul_b = e_ext;
			end
			S_U_DR: begin
				mul_a = MULW'(dgain_q);
				mul_b = diff;
			end
			default: ;
		endcase

		rnd = (acc_q + ACCW'(8192)) >>> 14;
		sat_hi = (rnd > ACCW'(dmax_q)) ? ACCW'(dmax_q) : rnd;
		sat = (sat_hi < ACCW'(dmin_q)) ? ACCW'(dmin_q) : sat_hi;

		dw_en = 1'b0;
		dw_addr = k_q[AW-1:0];
		dw_data = '0;
		ew_en = 1'b0;
		ew_addr = k_q[AW-1:0];
		ew_data = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && cmd.func == FN_RECORD && in_range) begin
					ew_en = 1'b1;
					ew_addr = AW'(cmd.sample_index);
					ew_data = cmd.error_value;
				end
			end
			S_U_WR: begin
				dw_en = 1'b1;
				dw_data = sat[SW-1:0];
				ew_en = 1'b1;
			end
			S_SWEEP: ew_en = !k_end;
			S_CLR: begin
				dw_en = !k_end;
				ew_en = !k_end;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (dw_en) begin
			drive_mem[dw_addr] <= dw_data;
		end
		du_q <= drive_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ew_en) begin
			err_mem[ew_addr] <= ew_data;
		end
		de_q <= err_mem[rd_addr];
	end

	ilf_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	ilf_root #(
		.SUMW (SUMW),
		.CW   (CW)
	) u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rstart_q),
		.sum    (sum_q),
		.count  (n_used),
		.done   (rt_done),
		.root   (rt_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			init_q <= 1'b1;
			k_q <= '0;
			op_q <= FN_READ;
			prior_q <= '0;
			trial_q <= '0;
			rms_q <= '0;
			rdone_q <= 1'b0;
			rstart_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			rstart_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q <= cmd.func;
						inr_q <= in_range;
						case (cmd.func)
							FN_END: begin
								k_q <= '0;
								sum_q <= '0;
								prev_q <= prior_q;
								rdone_q <= 1'b0;
								state_q <= S_U_RD;
							end
							FN_CLEAR: begin
								k_q <= '0;
								prior_q <= '0;
								trial_q <= '0;
								rms_q <= '0;
								state_q <= S_CLR;
							end
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_RESP: begin
					done_q <= 1'b1;
					result_q.drive_value <= (op_q == FN_READ && inr_q) ? du_q : '0;
					result_q.rms_error <= rms_q;
					result_q.trial_number <= trial_q;
					state_q <= S_IDLE;
				end
				S_U_RD: state_q <= S_U_SQ;
				S_U_SQ: state_q <= S_U_FU;
				S_U_FU: begin
					sum_q <= sum_q + SUMW'(prod[2*SW-1:0]);
					state_q <= S_U_PE;
				end
				S_U_PE: begin
					acc_q <= ACCW'(prod);
					state_q <= S_U_DR;
				end
				S_U_DR: begin
					acc_q <= acc_q + ACCW'(prod);
					state_q <= S_U_AD;
				end
				S_U_AD: begin
					if (mode_q) begin
						acc_q <= acc_q + (ACCW'(prod) <<< 6);
					end
					state_q <= S_U_WR;
				end
				S_U_WR: begin
					prev_q <= de_q;
					k_q <= k_q + CW'(1);
					if (k_q + CW'(1) == n_used) begin
						rstart_q <= 1'b1;
						state_q <= S_SWEEP;
					end else begin
						state_q <= S_U_RD;
					end
				end
				S_SWEEP: begin
					if (!k_end) begin
						k_q <= k_q + CW'(1);
					end
					if (rt_done) begin
						rms_q <= rt_root;
						rdone_q <= 1'b1;
					end
					if (k_end && rdone_q) begin
						trial_q <= trial_q + TRIALW'(1);
						prior_q <= prev_q;
						state_q <= S_RESP;
					end
				end
				S_CLR: begin
					if (!k_end) begin
						k_q <= k_q + CW'(1);
					end else begin
						init_q <= 1'b0;
						state_q <= init_q ? S_IDLE : S_RESP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign result = result_q;

	// a result beat only ever closes a command
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a command in flight");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_root_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		rt_done |-> (state_q == S_SWEEP))
		else $error("root unit finished outside the end of trial tail");

endmodule
